/* src/rmq_pkg.sv */
`timescale 1ns / 1ps
// shared widths, types and branch codes for the rotation matrix to quaternion pipeline
// no dependencies
package rmq_pkg;

   localparam int WORD_W = 18;
   localparam int FRAC_W = 16;

   // wide enough for any radicand sum, signed
   localparam int SUM_W  = WORD_W + 3;
   // a positive radicand is below 3*2^(WORD_W-1) + 2^FRAC_W
   localparam int RAD_W  = WORD_W + 1;
   localparam int ROOT_W = (RAD_W + FRAC_W + 1) / 2;
   localparam int REM_W  = 2 * ROOT_W;
   localparam int MAG_W  = WORD_W + 1;
   localparam int NUM_W  = MAG_W + FRAC_W + 1;
   localparam int DEN_W  = ROOT_W + 1;
   localparam int QUO_W  = WORD_W + 1;
   localparam int DIAG_W = ROOT_W - 1;
   localparam int LANES  = 3;

   localparam int ONE_VAL  = 1 << FRAC_W;
   localparam int HALF_VAL = 1 << (FRAC_W - 1);

   // accept edge to the edge at which the result strobe is sampled
   localparam int RSP_LATENCY = ROOT_W + QUO_W + 3;

   typedef enum logic [1:0] {
      CASE_TRACE = 2'd0,
      CASE_X     = 2'd1,
      CASE_Y     = 2'd2,
      CASE_Z     = 2'd3
   } case_type;

   typedef struct packed {
      case_type                     sel;
      logic                         bad;
      logic [LANES-1:0]             neg;
      logic [LANES-1:0][MAG_W-1:0]  mag;
   } sqrt_side_type;

   typedef struct packed {
      case_type           sel;
      logic               bad;
      logic [LANES-1:0]   neg;
      logic [DIAG_W-1:0]  diag;
   } div_side_type;

endpackage

/* src/rotation_matrix_to_quaternion.sv */
`timescale 1ns / 1ps
// Converts a 3x3 rotation matrix (signed Q1.16 entries) to a quaternion by Shepperd's
// method. A new matrix is taken every cycle; busy is always low. Each result appears on
// the rsp_ ports for one cycle with rsp_valid high, once its start transfer has passed
// one radicand stage, 18 square root stages, 20 divider stages and one output register.
// The receiver cannot stall, so results must be captured when rsp_valid is high.
// Depends on rmq_pkg, rmq_front, rmq_sqrt, rmq_div, rmq_back.
module rotation_matrix_to_quaternion import rmq_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic signed [WORD_W-1:0] req_m00,
   input  logic signed [WORD_W-1:0] req_m01,
   input  logic signed [WORD_W-1:0] req_m02,
   input  logic signed [WORD_W-1:0] req_m10,
   input  logic signed [WORD_W-1:0] req_m11,
   input  logic signed [WORD_W-1:0] req_m12,
   input  logic signed [WORD_W-1:0] req_m20,
   input  logic signed [WORD_W-1:0] req_m21,
   input  logic signed [WORD_W-1:0] req_m22,
   output logic                     rsp_valid,
   output logic signed [WORD_W-1:0] rsp_quat_w,
   output logic signed [WORD_W-1:0] rsp_quat_x,
   output logic signed [WORD_W-1:0] rsp_quat_y,
   output logic signed [WORD_W-1:0] rsp_quat_z,
   output logic [1:0]               rsp_case_taken,
   output logic                     rsp_invalid
);

   logic [RAD_W-1:0]            front_rad;
   sqrt_side_type               front_side;
   logic                        sq_valid;
   logic [ROOT_W-1:0]           sq_root;
   sqrt_side_type               sq_side;
   logic                        dv_valid;
   logic [LANES-1:0][QUO_W-1:0] dv_quo;
   div_side_type                dv_side;

   assign busy = 1'b0;

   rmq_front u_front (
      .m00(req_m00), .m01(req_m01), .m02(req_m02),
      .m10(req_m10), .m11(req_m11), .m12(req_m12),
      .m20(req_m20), .m21(req_m21), .m22(req_m22),
      .rad(front_rad),
      .side(front_side)
   );

   rmq_sqrt u_sqrt (
      .clock(clock),
      .reset(reset),
      .in_valid(start && !busy),
      .in_rad(front_rad),
      .in_side(front_side),
      .out_valid(sq_valid),
      .out_root(sq_root),
      .out_side(sq_side)
   );

   rmq_div u_div (
      .clock(clock),
      .reset(reset),
      .in_valid(sq_valid),
      .in_root(sq_root),
      .in_side(sq_side),
      .out_valid(dv_valid),
      .out_quo(dv_quo),
      .out_side(dv_side)
   );

   rmq_back u_back (
      .clock(clock),
      .reset(reset),
      .in_valid(dv_valid),
      .in_quo(dv_quo),
      .in_side(dv_side),
      .out_valid(rsp_valid),
      .out_w(rsp_quat_w),
      .out_x(rsp_quat_x),
      .out_y(rsp_quat_y),
      .out_z(rsp_quat_z),
      .out_case(rsp_case_taken),
      .out_invalid(rsp_invalid)
   );

endmodule

/* src/rmq_front.sv */
`timescale 1ns / 1ps
// radicands, branch choice and off-diagonal sums/differences
// depends on rmq_pkg
module rmq_front import rmq_pkg::*; (
   input  logic signed [WORD_W-1:0] m00,
   input  logic signed [WORD_W-1:0] m01,
   input  logic signed [WORD_W-1:0] m02,
   input  logic signed [WORD_W-1:0] m10,
   input  logic signed [WORD_W-1:0] m11,
   input  logic signed [WORD_W-1:0] m12,
   input  logic signed [WORD_W-1:0] m20,
   input  logic signed [WORD_W-1:0] m21,
   input  logic signed [WORD_W-1:0] m22,
   output logic [RAD_W-1:0]         rad,
   output sqrt_side_type            side
);

   logic signed [SUM_W-1:0] a00, a11, a22, one_s, half_s;
   logic signed [SUM_W-1:0] tr, xr, yr, zr, r;
   logic signed [MAG_W:0]   d_w0, d_w1, d_w2, s_xy, s_xz, s_yz;
   logic signed [MAG_W:0]   d [LANES];
   case_type                sel;

   always_comb begin
      a00    = SUM_W'(m00);
      a11    = SUM_W'(m11);
      a22    = SUM_W'(m22);
      one_s  = SUM_W'(ONE_VAL);
      half_s = SUM_W'(HALF_VAL);
      tr = a00 + a11 + a22 + one_s;
      xr = one_s + a00 - a11 - a22;
      yr = one_s + a11 - a00 - a22;
      zr = one_s + a22 - a00 - a11;

      d_w0 = (MAG_W+1)'(m21) - (MAG_W+1)'(m12);
      d_w1 = (MAG_W+1)'(m02) - (MAG_W+1)'(m20);
      d_w2 = (MAG_W+1)'(m10) - (MAG_W+1)'(m01);
      s_xy = (MAG_W+1)'(m01) + (MAG_W+1)'(m10);
      s_xz = (MAG_W+1)'(m02) + (MAG_W+1)'(m20);
      s_yz = (MAG_W+1)'(m12) + (MAG_W+1)'(m21);

      if (tr > half_s) begin
         sel = CASE_TRACE;
         r   = tr;
      end else if (xr > one_s) begin
         sel = CASE_X;
         r   = xr;
      end else if (yr > one_s) begin
         sel = CASE_Y;
         r   = yr;
      end else begin
         sel = CASE_Z;
         r   = zr;
      end

      // lanes feed the three non-diagonal components in w, x, y, z order
      case (sel)
         CASE_TRACE: begin
            d[0] = d_w0; d[1] = d_w1; d[2] = d_w2;
         end
         CASE_X: begin
            d[0] = d_w0; d[1] = s_xy; d[2] = s_xz;
         end
         CASE_Y: begin
            d[0] = d_w1; d[1] = s_xy; d[2] = s_yz;
         end
         default: begin
            d[0] = d_w2; d[1] = s_xz; d[2] = s_yz;
         end
      endcase

      side.sel = sel;
      side.bad = (r <= 0);
      for (int l = 0; l < LANES; l++) begin
         side.neg[l] = d[l][MAG_W];
         side.mag[l] = d[l][MAG_W] ? MAG_W'(-d[l]) : MAG_W'(d[l]);
      end
      rad = side.bad ? '0 : RAD_W'(r);
   end

endmodule

/* src/rmq_sqrt.sv */
`timescale 1ns / 1ps
// pipelined integer square root of rad * 2^FRAC_W, one root bit per stage
// depends on rmq_pkg
module rmq_sqrt import rmq_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  logic [RAD_W-1:0]   in_rad,
   input  sqrt_side_type      in_side,
   output logic               out_valid,
   output logic [ROOT_W-1:0]  out_root,
   output sqrt_side_type      out_side
);

   localparam int TRY_W = REM_W + 1;

   logic [REM_W-1:0]  rem_ff   [0:ROOT_W];
   logic [REM_W-1:0]  rem_in   [0:ROOT_W];
   logic [ROOT_W-1:0] root_ff  [0:ROOT_W];
   logic [ROOT_W-1:0] root_in  [0:ROOT_W];
   sqrt_side_type     side_ff  [0:ROOT_W];
   sqrt_side_type     side_in  [0:ROOT_W];
   logic              valid_ff [0:ROOT_W];
   logic              valid_in [0:ROOT_W];

   always_comb begin
      rem_in[0]   = REM_W'({in_rad, {FRAC_W{1'b0}}});
      root_in[0]  = '0;
      side_in[0]  = in_side;
      valid_in[0] = in_valid;
   end

   for (genvar g = 0; g < ROOT_W; g++) begin : g_step
      localparam int B = ROOT_W - 1 - g;
      logic [TRY_W-1:0] trial, rem_x;
      logic             ge;
      always_comb begin
         // (r + 2^B)^2 - r^2
         trial = (TRY_W'(root_ff[g]) << (B + 1)) + (TRY_W'(1) << (2 * B));
         rem_x = TRY_W'(rem_ff[g]);
         ge    = (rem_x >= trial);
         rem_in[g+1]   = ge ? REM_W'(rem_x - trial) : rem_ff[g];
         root_in[g+1]  = ge ? (root_ff[g] | (ROOT_W'(1) << B)) : root_ff[g];
         side_in[g+1]  = side_ff[g];
         valid_in[g+1] = valid_ff[g];
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k <= ROOT_W; k++) begin
         rem_ff[k]  <= rem_in[k];
         root_ff[k] <= root_in[k];
         side_ff[k] <= side_in[k];
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else begin
            valid_ff[k] <= valid_in[k];
         end
      end
   end

   assign out_valid = valid_ff[ROOT_W];
   assign out_root  = root_ff[ROOT_W];
   assign out_side  = side_ff[ROOT_W];

endmodule

/* src/rmq_div.sv */
`timescale 1ns / 1ps
// three-lane pipelined restoring divider: (mag*2^FRAC_W + root) / (2*root)
// depends on rmq_pkg
module rmq_div import rmq_pkg::*; (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   input  logic [ROOT_W-1:0]            in_root,
   input  sqrt_side_type                in_side,
   output logic                         out_valid,
   output logic [LANES-1:0][QUO_W-1:0]  out_quo,
   output div_side_type                 out_side
);

   localparam int CMP_W = DEN_W + QUO_W;

   logic [LANES-1:0][NUM_W-1:0] rem_ff   [0:QUO_W];
   logic [LANES-1:0][NUM_W-1:0] rem_in   [0:QUO_W];
   logic [LANES-1:0][QUO_W-1:0] quo_ff   [0:QUO_W];
   logic [LANES-1:0][QUO_W-1:0] quo_in   [0:QUO_W];
   logic [DEN_W-1:0]            den_ff   [0:QUO_W];
   logic [DEN_W-1:0]            den_in   [0:QUO_W];
   div_side_type                side_ff  [0:QUO_W];
   div_side_type                side_in  [0:QUO_W];
   logic                        valid_ff [0:QUO_W];
   logic                        valid_in [0:QUO_W];

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         // adding root gives round half away from zero on the magnitude
         rem_in[0][l] = NUM_W'({in_side.mag[l], {FRAC_W{1'b0}}}) + NUM_W'(in_root);
         quo_in[0][l] = '0;
      end
      den_in[0]       = {in_root, 1'b0};
      side_in[0].sel  = in_side.sel;
      side_in[0].bad  = in_side.bad;
      side_in[0].neg  = in_side.neg;
      side_in[0].diag = in_root[ROOT_W-1:1];
      valid_in[0]     = in_valid;
   end

   for (genvar g = 0; g < QUO_W; g++) begin : g_step
      localparam int B = QUO_W - 1 - g;
      logic [CMP_W-1:0] sh;
      assign sh = CMP_W'(den_ff[g]) << B;
      for (genvar l = 0; l < LANES; l++) begin : g_lane
         logic [CMP_W-1:0] rem_x;
         logic             ge;
         always_comb begin
            rem_x = CMP_W'(rem_ff[g][l]);
            ge    = (rem_x >= sh);
            rem_in[g+1][l] = ge ? NUM_W'(rem_x - sh) : rem_ff[g][l];
            quo_in[g+1][l] = quo_ff[g][l] | (ge ? (QUO_W'(1) << B) : '0);
         end
      end
      always_comb begin
         den_in[g+1]   = den_ff[g];
         side_in[g+1]  = side_ff[g];
         valid_in[g+1] = valid_ff[g];
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k <= QUO_W; k++) begin
         rem_ff[k]  <= rem_in[k];
         quo_ff[k]  <= quo_in[k];
         den_ff[k]  <= den_in[k];
         side_ff[k] <= side_in[k];
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else begin
            valid_ff[k] <= valid_in[k];
         end
      end
   end

   assign out_valid = valid_ff[QUO_W];
   assign out_quo   = quo_ff[QUO_W];
   assign out_side  = side_ff[QUO_W];

endmodule

/* src/rmq_back.sv */
`timescale 1ns / 1ps
// sign, saturation, zeroing of invalid results and component placement into the result register
// depends on rmq_pkg
module rmq_back import rmq_pkg::*; (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   input  logic [LANES-1:0][QUO_W-1:0]  in_quo,
   input  div_side_type                 in_side,
   output logic                         out_valid,
   output logic signed [WORD_W-1:0]     out_w,
   output logic signed [WORD_W-1:0]     out_x,
   output logic signed [WORD_W-1:0]     out_y,
   output logic signed [WORD_W-1:0]     out_z,
   output logic [1:0]                   out_case,
   output logic                         out_invalid
);

   localparam logic [WORD_W-1:0] MAX_POS = {1'b0, {(WORD_W-1){1'b1}}};
   localparam logic [WORD_W-1:0] MAX_NEG = {1'b1, {(WORD_W-1){1'b0}}};

   logic [WORD_W-1:0] lane_val [LANES];
   logic [WORD_W-1:0] diag_val;
   logic [WORD_W-1:0] w_in, x_in, y_in, z_in;
   logic [WORD_W-1:0] w_ff, x_ff, y_ff, z_ff;
   logic [1:0]        case_ff;
   logic              invalid_ff, valid_ff;

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         if (in_quo[l][QUO_W-1:WORD_W-1] != '0) begin
            lane_val[l] = in_side.neg[l] ? MAX_NEG : MAX_POS;
         end else begin
            lane_val[l] = in_side.neg[l] ? WORD_W'(-in_quo[l]) : WORD_W'(in_quo[l]);
         end
      end
      diag_val = WORD_W'(in_side.diag);
      case (in_side.sel)
         CASE_TRACE: begin
            w_in = diag_val; x_in = lane_val[0]; y_in = lane_val[1]; z_in = lane_val[2];
         end
         CASE_X: begin
            w_in = lane_val[0]; x_in = diag_val; y_in = lane_val[1]; z_in = lane_val[2];
         end
         CASE_Y: begin
            w_in = lane_val[0]; x_in = lane_val[1]; y_in = diag_val; z_in = lane_val[2];
         end
         default: begin
            w_in = lane_val[0]; x_in = lane_val[1]; y_in = lane_val[2]; z_in = diag_val;
         end
      endcase
      if (in_side.bad) begin
         w_in = '0; x_in = '0; y_in = '0; z_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      w_ff       <= w_in;
      x_ff       <= x_in;
      y_ff       <= y_in;
      z_ff       <= z_in;
      case_ff    <= in_side.sel;
      invalid_ff <= in_side.bad;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   assign out_valid   = valid_ff;
   assign out_w       = w_ff;
   assign out_x       = x_ff;
   assign out_y       = y_ff;
   assign out_z       = z_ff;
   assign out_case    = case_ff;
   assign out_invalid = invalid_ff;

endmodule

/* src/rmq_checker.sv */
`timescale 1ns / 1ps
// port-level checks for rotation_matrix_to_quaternion, bound to the top level
// depends on rmq_pkg
module rmq_checker import rmq_pkg::*; (
   input logic                     clock,
   input logic                     reset,
   input logic                     start,
   input logic                     busy,
   input logic                     rsp_valid,
   input logic signed [WORD_W-1:0] rsp_quat_w,
   input logic signed [WORD_W-1:0] rsp_quat_x,
   input logic signed [WORD_W-1:0] rsp_quat_y,
   input logic signed [WORD_W-1:0] rsp_quat_z,
   input logic [1:0]               rsp_case_taken,
   input logic                     rsp_invalid
);

   // every start transfer yields exactly one strobe a fixed latency later
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##RSP_LATENCY rsp_valid)
      else $error("missing result after start transfer");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, RSP_LATENCY))
      else $error("result without matching start transfer");

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_invalid) |->
         (rsp_quat_w == '0 && rsp_quat_x == '0 && rsp_quat_y == '0 && rsp_quat_z == '0))
      else $error("invalid result with nonzero quaternion");

   // only the z fallback can have a non-positive radicand
   a_invalid_z: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_invalid) |-> (rsp_case_taken == CASE_Z))
      else $error("invalid flag outside the z branch");

endmodule

bind rotation_matrix_to_quaternion rmq_checker u_rmq_checker (
   .clock(clock),
   .reset(reset),
   .start(start),
   .busy(busy),
   .rsp_valid(rsp_valid),
   .rsp_quat_w(rsp_quat_w),
   .rsp_quat_x(rsp_quat_x),
   .rsp_quat_y(rsp_quat_y),
   .rsp_quat_z(rsp_quat_z),
   .rsp_case_taken(rsp_case_taken),
   .rsp_invalid(rsp_invalid)
);
